/* rtl/wus_pkg.sv */
// wus_pkg: sizes, command and status codes shared by the weighted urn sampler
// no dependencies; compiled before the interfaces and modules

package wus_pkg;

   localparam int MAX_ENTRIES = 64;
   localparam int WEIGHT_BITS = 16;
   localparam int COUNT_BITS  = 16;

   localparam int IDX_BITS   = $clog2(MAX_ENTRIES);
   localparam int ACT_BITS   = IDX_BITS + 1;
   localparam int TOTAL_BITS = WEIGHT_BITS + IDX_BITS;

   localparam int CMD_W    = 3;
   localparam int ENTRY_W  = 6;
   localparam int AMOUNT_W = 16;
   localparam int RANDOM_W = 31;
   localparam int STATUS_W = 2;
   localparam int DRAWN_W  = 6;

   typedef enum logic [CMD_W-1:0] {
      CMD_DRAW    = 3'd0,
      CMD_SET     = 3'd1,
      CMD_INC     = 3'd2,
      CMD_EQUAL   = 3'd3,
      CMD_RESTART = 3'd4,
      CMD_RESIZE  = 3'd5
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_DONE   = 2'd0,
      STS_DRAWN  = 2'd1,
      STS_EMPTY  = 2'd2,
      STS_REJECT = 2'd3
   } status_type;

endpackage

/* rtl/wus_req_if.sv */
// wus_req_if: command channel of the urn sampler, valid/ready plus payload
// depends on wus_pkg for field widths

interface wus_req_if;
   import wus_pkg::*;

   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [ENTRY_W-1:0]  entry_index;
   logic [AMOUNT_W-1:0] amount;
   logic [RANDOM_W-1:0] random_word;

   modport source (output valid, command, entry_index, amount, random_word, input ready);
   modport sink (input valid, command, entry_index, amount, random_word, output ready);
endinterface

/* rtl/wus_rsp_if.sv */
// wus_rsp_if: result channel of the urn sampler, valid/ready plus payload
// depends on wus_pkg for field widths

interface wus_rsp_if;
   import wus_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [DRAWN_W-1:0]  drawn_entry;
   logic                cycle_end;

   modport source (output valid, status, drawn_entry, cycle_end, input ready);
   modport sink (input valid, status, drawn_entry, cycle_end, output ready);
endinterface

/* rtl/wus_divider.sv */
// wus_divider: restoring remainder unit, one quotient bit per cycle
// depends on wus_pkg for the random word and pool total widths

module wus_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [wus_pkg::RANDOM_W-1:0]   dividend,
   input  logic [wus_pkg::TOTAL_BITS-1:0] divisor,
   output logic                           done,
   output logic [wus_pkg::TOTAL_BITS-1:0] remainder
);
   import wus_pkg::*;

   localparam int STEP_BITS = $clog2(RANDOM_W + 1);

   logic                  busy_ff;
   logic                  done_ff;
   logic [STEP_BITS-1:0]  step_ff;
   logic [RANDOM_W-1:0]   shift_ff;
   logic [TOTAL_BITS-1:0] div_ff;
   logic [TOTAL_BITS-1:0] rem_ff;
   logic [TOTAL_BITS:0]   trial;
   logic [TOTAL_BITS-1:0] rem_in;

   // remainder stays below the divisor, so one subtract per bit is enough
   always_comb begin
      trial = {rem_ff, shift_ff[RANDOM_W-1]};
      if (trial >= {1'b0, div_ff}) begin
         rem_in = TOTAL_BITS'(trial - {1'b0, div_ff});
      end else begin
         rem_in = trial[TOTAL_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            step_ff  <= STEP_BITS'(RANDOM_W);
            shift_ff <= dividend;
            div_ff   <= divisor;
            rem_ff   <= '0;
         end else if (busy_ff) begin
            rem_ff   <= rem_in;
            shift_ff <= {shift_ff[RANDOM_W-2:0], 1'b0};
            step_ff  <= step_ff - STEP_BITS'(1);
            if (step_ff == STEP_BITS'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

/* rtl/weighted_urn_sampler.sv */
// weighted_urn_sampler: weighted draw without replacement over an urn of entries
// depends on wus_pkg, wus_req_if, wus_rsp_if and wus_divider
//
//   channel   direction  contents
//   req_chan  in         command, entry_index, amount, random_word
//   rsp_chan  out        status, drawn_entry, cycle_end
//
// one command at a time. a draw walks the weight/count memories twice (one
// entry per cycle, registered reads) around the remainder unit.
// reset clears the per-entry valid flops, which stand in for the memory reset.
// results wait in an output register; a stalled result holds only the next one.

module weighted_urn_sampler (
   input logic       clock,
   input logic       reset,
   wus_req_if.sink   req_chan,
   wus_rsp_if.source rsp_chan
);
   import wus_pkg::*;

   localparam int CMP_W = (ENTRY_W > ACT_BITS) ? ENTRY_W : ACT_BITS;
   localparam int SAT_W = (WEIGHT_BITS > AMOUNT_W) ? WEIGHT_BITS : AMOUNT_W;
   localparam int OWE_W = (WEIGHT_BITS > COUNT_BITS) ? WEIGHT_BITS : COUNT_BITS;
   localparam logic [WEIGHT_BITS-1:0] WEIGHT_MAX = '1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_INC_WR,
      ST_SUM,
      ST_MOD,
      ST_SEARCH,
      ST_RESP
   } state_type;

   function automatic logic [WEIGHT_BITS-1:0] sat_amount(input logic [AMOUNT_W-1:0] a);
      logic [SAT_W-1:0] wide;
      wide = SAT_W'(a);
      if (wide > SAT_W'(WEIGHT_MAX)) begin
         return WEIGHT_MAX;
      end
      return WEIGHT_BITS'(wide);
   endfunction

   function automatic logic [WEIGHT_BITS-1:0] owed(input logic [WEIGHT_BITS-1:0] w,
                                                   input logic [COUNT_BITS-1:0]  c);
      logic [OWE_W-1:0] ww;
      logic [OWE_W-1:0] cc;
      ww = OWE_W'(w);
      cc = OWE_W'(c);
      if (ww > cc) begin
         return WEIGHT_BITS'(ww - cc);
      end
      return '0;
   endfunction

   state_type             state_ff;
   cmd_type               cmd_ff;
   logic [ENTRY_W-1:0]    idx_ff;
   logic [AMOUNT_W-1:0]   amount_ff;
   logic [RANDOM_W-1:0]   random_ff;
   logic [ACT_BITS-1:0]   active_ff;
   logic [WEIGHT_BITS-1:0] default_w_ff;
   logic [TOTAL_BITS-1:0] total_ff;
   logic [TOTAL_BITS-1:0] acc_ff;
   logic [TOTAL_BITS-1:0] pick_ff;
   logic [ACT_BITS-1:0]   issue_ff;
   logic                  div_start_ff;
   status_type            res_status_ff;
   logic [DRAWN_W-1:0]    res_drawn_ff;
   logic                  res_cend_ff;
   logic                  rsp_valid_ff;
   status_type            rsp_status_ff;
   logic [DRAWN_W-1:0]    rsp_drawn_ff;
   logic                  rsp_cend_ff;

   logic [WEIGHT_BITS-1:0] weight_mem [MAX_ENTRIES];
   logic [COUNT_BITS-1:0]  count_mem [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] wvalid_ff;
   logic [MAX_ENTRIES-1:0] cvalid_ff;

   logic [WEIGHT_BITS-1:0] w_rd_ff;
   logic [COUNT_BITS-1:0]  c_rd_ff;
   logic                   wv_rd_ff;
   logic                   cv_rd_ff;
   logic [IDX_BITS-1:0]    rd_idx_ff;
   logic                   rd_vld_ff;

   logic [IDX_BITS-1:0]    rd_addr;
   logic                   issuing;
   logic [WEIGHT_BITS-1:0] w_eff;
   logic [COUNT_BITS-1:0]  c_eff;
   logic [TOTAL_BITS-1:0]  acc_sum;
   logic                   found;
   logic                   in_range;
   logic [ACT_BITS-1:0]    resize_n;
   logic [WEIGHT_BITS-1:0] equal_w;

   logic                   wmem_we;
   logic                   cmem_we;
   logic [IDX_BITS-1:0]    wr_addr;
   logic [WEIGHT_BITS-1:0] wr_weight;
   logic [COUNT_BITS-1:0]  wr_count;
   logic                   set_wv;
   logic                   set_cv;
   logic                   clr_wv;
   logic                   clr_cv;

   logic                   div_done;
   logic [TOTAL_BITS-1:0]  div_rem;

   wus_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start_ff),
      .dividend  (random_ff),
      .divisor   (total_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   assign issuing = ((state_ff == ST_SUM) || (state_ff == ST_SEARCH)) && (issue_ff < active_ff);
   assign rd_addr = (state_ff == ST_EXEC) ? IDX_BITS'(idx_ff) : issue_ff[IDX_BITS-1:0];

   // entries never written since the last bulk change read as the default
   assign w_eff   = wv_rd_ff ? w_rd_ff : default_w_ff;
   assign c_eff   = cv_rd_ff ? c_rd_ff : '0;
   assign acc_sum = acc_ff + TOTAL_BITS'(owed(w_eff, c_eff));
   assign found   = rd_vld_ff && (pick_ff < acc_sum);

   assign in_range = CMP_W'(idx_ff) < CMP_W'(active_ff);
   assign equal_w  = sat_amount((amount_ff == '0) ? AMOUNT_W'(1) : amount_ff);

   always_comb begin
      if (amount_ff == '0) begin
         resize_n = ACT_BITS'(1);
      end else if (amount_ff > AMOUNT_W'(MAX_ENTRIES)) begin
         resize_n = ACT_BITS'(MAX_ENTRIES);
      end else begin
         resize_n = ACT_BITS'(amount_ff);
      end
   end

   always_comb begin
      wmem_we   = 1'b0;
      cmem_we   = 1'b0;
      wr_addr   = IDX_BITS'(idx_ff);
      wr_weight = sat_amount(amount_ff);
      wr_count  = c_eff + COUNT_BITS'(1);
      set_wv    = 1'b0;
      set_cv    = 1'b0;
      clr_wv    = 1'b0;
      clr_cv    = 1'b0;
      case (state_ff)
         ST_EXEC: begin
            case (cmd_ff)
               CMD_SET: begin
                  wmem_we = in_range;
                  set_wv  = in_range;
               end
               CMD_EQUAL: begin
                  clr_wv = 1'b1;
                  clr_cv = 1'b1;
               end
               CMD_RESTART: begin
                  clr_cv = 1'b1;
               end
               CMD_RESIZE: begin
                  clr_wv = (resize_n != active_ff);
                  clr_cv = (resize_n != active_ff);
               end
               default: begin
               end
            endcase
         end
         ST_INC_WR: begin
            wmem_we   = 1'b1;
            set_wv    = 1'b1;
            wr_weight = (w_eff == WEIGHT_MAX) ? w_eff : w_eff + WEIGHT_BITS'(1);
         end
         ST_SEARCH: begin
            wr_addr = rd_idx_ff;
            cmem_we = found;
            set_cv  = found;
            // last token gone: all counts drop back to zero
            clr_cv  = found && (total_ff == TOTAL_BITS'(1));
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wmem_we) begin
         weight_mem[wr_addr] <= wr_weight;
      end
      if (cmem_we) begin
         count_mem[wr_addr] <= wr_count;
      end
      w_rd_ff   <= weight_mem[rd_addr];
      c_rd_ff   <= count_mem[rd_addr];
      wv_rd_ff  <= wvalid_ff[rd_addr];
      cv_rd_ff  <= cvalid_ff[rd_addr];
      rd_idx_ff <= rd_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wvalid_ff <= '0;
         cvalid_ff <= '0;
      end else begin
         if (clr_wv) begin
            wvalid_ff <= '0;
         end else if (set_wv) begin
            wvalid_ff[wr_addr] <= 1'b1;
         end
         if (clr_cv) begin
            cvalid_ff <= '0;
         end else if (set_cv) begin
            cvalid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= ACT_BITS'(1);
         default_w_ff <= WEIGHT_BITS'(1);
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
         div_start_ff <= 1'b0;
         issue_ff     <= '0;
      end else begin
         rd_vld_ff    <= issuing;
         div_start_ff <= 1'b0;
         if (issuing) begin
            issue_ff <= issue_ff + ACT_BITS'(1);
         end
         if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_chan.valid) begin
                  cmd_ff    <= cmd_type'(req_chan.command);
                  idx_ff    <= req_chan.entry_index;
                  amount_ff <= req_chan.amount;
                  random_ff <= req_chan.random_word;
                  state_ff  <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               res_status_ff <= STS_DONE;
               res_drawn_ff  <= '0;
               res_cend_ff   <= 1'b0;
               state_ff      <= ST_RESP;
               case (cmd_ff)
                  CMD_DRAW: begin
                     issue_ff <= '0;
                     acc_ff   <= '0;
                     state_ff <= ST_SUM;
                  end
                  CMD_SET: begin
                     if (!in_range) begin
                        res_status_ff <= STS_REJECT;
                     end
                  end
                  CMD_INC: begin
                     if (!in_range) begin
                        res_status_ff <= STS_REJECT;
                     end else begin
                        state_ff <= ST_INC_WR;
                     end
                  end
                  CMD_EQUAL: begin
                     default_w_ff <= equal_w;
                  end
                  CMD_RESIZE: begin
                     if (resize_n != active_ff) begin
                        active_ff    <= resize_n;
                        default_w_ff <= WEIGHT_BITS'(1);
                     end
                  end
                  default: begin
                  end
               endcase
            end
            ST_INC_WR: begin
               state_ff <= ST_RESP;
            end
            ST_SUM: begin
               if (rd_vld_ff) begin
                  acc_ff <= acc_sum;
               end else if (issue_ff == active_ff) begin
                  total_ff <= acc_ff;
                  if (acc_ff == '0) begin
                     res_status_ff <= STS_EMPTY;
                     state_ff      <= ST_RESP;
                  end else begin
                     div_start_ff <= 1'b1;
                     state_ff     <= ST_MOD;
                  end
               end
            end
            ST_MOD: begin
               if (div_done) begin
                  pick_ff  <= div_rem;
                  issue_ff <= '0;
                  acc_ff   <= '0;
                  state_ff <= ST_SEARCH;
               end
            end
            ST_SEARCH: begin
               if (rd_vld_ff) begin
                  acc_ff <= acc_sum;
               end
               if (found) begin
                  res_status_ff <= STS_DRAWN;
                  res_drawn_ff  <= DRAWN_W'(rd_idx_ff);
                  res_cend_ff   <= (total_ff == TOTAL_BITS'(1));
                  state_ff      <= ST_RESP;
               end
            end
            ST_RESP: begin
               // wait for the output register to free up
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_drawn_ff  <= res_drawn_ff;
                  rsp_cend_ff   <= res_cend_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.drawn_entry = rsp_drawn_ff;
   assign rsp_chan.cycle_end   = rsp_cend_ff;

`ifndef ASSERT_OFF
   a_one_command: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("command accepted while another is in flight");

   a_search_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> (acc_ff < total_ff))
      else $error("search ran past the pool total");

   a_result_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_cend_ff || (rsp_drawn_ff != '0))) |-> (rsp_status_ff == STS_DRAWN))
      else $error("draw fields set on a result that is not a draw");

   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_MOD))
      else $error("remainder finished outside the modulo step");
`endif

endmodule

/* tb/sv/urn_result_checker.sv */
// urn_result_checker: watches both channels of the urn sampler, keeps its own copy of
// the urn state, predicts every result and compares it; depends on wus_pkg and both interfaces

module urn_result_checker (
   input  logic        clock,
   input  logic        reset,
   wus_req_if          req_mon,
   wus_rsp_if          rsp_mon,
   output int unsigned mismatches,
   output int unsigned awaited_count
);
   import wus_pkg::*;

   typedef struct packed {
      status_type         status;
      logic [DRAWN_W-1:0] drawn_entry;
      logic               cycle_end;
   } urn_outcome_type;

   logic [ACT_BITS-1:0]    urn_size;
   logic [WEIGHT_BITS-1:0] weight_of [MAX_ENTRIES];
   logic [COUNT_BITS-1:0]  taken     [MAX_ENTRIES];
   urn_outcome_type        awaited_outcomes [$];
   int unsigned            fail_total;

   function automatic int unsigned still_owed(int k);
      return (weight_of[k] > taken[k]) ? int'(weight_of[k]) - int'(taken[k]) : 0;
   endfunction

   function automatic void clear_taken();
      for (int k = 0; k < MAX_ENTRIES; k++) taken[k] = '0;
   endfunction

   function automatic void refill_urn();
      urn_size = ACT_BITS'(1);
      for (int k = 0; k < MAX_ENTRIES; k++) weight_of[k] = WEIGHT_BITS'(1);
      clear_taken();
   endfunction

   // one command applied to the shadow urn, returning the result it should produce
   function automatic urn_outcome_type urn_outcome(logic [CMD_W-1:0] cmd,
                                                   logic [ENTRY_W-1:0] idx,
                                                   logic [AMOUNT_W-1:0] amt,
                                                   logic [RANDOM_W-1:0] rnd);
      urn_outcome_type o;
      int unsigned     total, pick, acc, size_req;
      int              k;
      o.status      = STS_DONE;
      o.drawn_entry = '0;
      o.cycle_end   = 1'b0;
      case (cmd)
         CMD_DRAW: begin
            total = 0;
            for (k = 0; k < int'(urn_size); k++) total += still_owed(k);
            if (total == 0) begin
               o.status = STS_EMPTY;
            end else begin
               // cumulative ranges of the owed remainders in index order
               pick = int'(rnd) % total;
               k    = 0;
               acc  = still_owed(0);
               while (pick >= acc) begin
                  k++;
                  acc += still_owed(k);
               end
               taken[k]      = taken[k] + 1'b1;
               o.status      = STS_DRAWN;
               o.drawn_entry = k[DRAWN_W-1:0];
               if (total == 1) begin
                  o.cycle_end = 1'b1;
                  clear_taken();
               end
            end
         end
         CMD_SET, CMD_INC: begin
            if (idx >= urn_size) begin
               o.status = STS_REJECT;
            end else if (cmd == CMD_SET) begin
               weight_of[idx] = amt;
            end else if (weight_of[idx] != {WEIGHT_BITS{1'b1}}) begin
               weight_of[idx] = weight_of[idx] + 1'b1;
            end
         end
         CMD_EQUAL: begin
            for (k = 0; k < MAX_ENTRIES; k++)
               weight_of[k] = (amt == '0) ? WEIGHT_BITS'(1) : WEIGHT_BITS'(amt);
            clear_taken();
         end
         CMD_RESTART: clear_taken();
         CMD_RESIZE: begin
            size_req = (amt == 0) ? 1 : (amt > MAX_ENTRIES) ? MAX_ENTRIES : int'(amt);
            if (size_req != urn_size) begin
               refill_urn();
               urn_size = size_req[ACT_BITS-1:0];
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   initial refill_urn();

   always @(posedge clock) begin
      urn_outcome_type want;
      if (reset) begin
         refill_urn();
         awaited_outcomes.delete();
         fail_total = 0;
      end else begin
         // results first: a result never belongs to a command accepted at the same edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (awaited_outcomes.size() == 0) begin
               if (fail_total < 10)
                  $display("unexpected result: status %0d entry %0d cycle_end %0d",
                           rsp_mon.status, rsp_mon.drawn_entry, rsp_mon.cycle_end);
               fail_total++;
            end else begin
               want = awaited_outcomes.pop_front();
               if (rsp_mon.status !== want.status ||
                   rsp_mon.drawn_entry !== want.drawn_entry ||
                   rsp_mon.cycle_end !== want.cycle_end) begin
                  if (fail_total < 10)
                     $display("result mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                              want.status, want.drawn_entry, want.cycle_end,
                              rsp_mon.status, rsp_mon.drawn_entry, rsp_mon.cycle_end);
                  fail_total++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            awaited_outcomes.push_back(urn_outcome(req_mon.command, req_mon.entry_index,
                                                   req_mon.amount, req_mon.random_word));
      end
      mismatches    <= fail_total;
      awaited_count <= awaited_outcomes.size();
   end

endmodule

/* tb/sv/weighted_urn_sampler_test.sv */
// weighted_urn_sampler_test: drives commands into the urn sampler and drains its results
// depends on wus_pkg, wus_req_if, wus_rsp_if, weighted_urn_sampler and urn_result_checker

module weighted_urn_sampler_test;
   import wus_pkg::*;

   localparam int RANDOM_ITEMS = 650;
   localparam int STALL_LIMIT  = 5000;
   localparam int HOLD_CYCLES  = 500;

   // command codes with no meaning, expected to complete as no-ops
   localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int unsigned mismatches, awaited_count;
   int          sent = 0;
   int          received = 0;
   int          quiet_cycles = 0;
   bit          calm_sender = 1'b0;
   bit          calm_receiver = 1'b0;

   wus_req_if req_chan ();
   wus_rsp_if rsp_chan ();

   weighted_urn_sampler DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   urn_result_checker result_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .mismatches    (mismatches),
      .awaited_count (awaited_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // one command transfer, after a random gap unless the sender is in a calm stretch
   task automatic send(input logic [CMD_W-1:0] cmd, input logic [ENTRY_W-1:0] idx,
                       input logic [AMOUNT_W-1:0] amt, input logic [RANDOM_W-1:0] rnd);
      int gap;
      gap = calm_sender ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.command     <= cmd;
      req_chan.entry_index <= idx;
      req_chan.amount      <= amt;
      req_chan.random_word <= rnd;
      do @(posedge clock); while (!req_chan.ready);
      sent++;
      if (sent % 40 == 0) calm_sender = ($urandom_range(0, 3) == 0);
   endtask

   task automatic draw(input logic [RANDOM_W-1:0] rnd);
      send(CMD_DRAW, ENTRY_W'($urandom()), AMOUNT_W'($urandom()), rnd);
   endtask

   // resize, load weights, then a run of mostly draws that can empty small urns
   task automatic fill_and_drain();
      int n, live, draws, k;
      case ($urandom_range(0, 9))
         0:       n = $urandom_range(7, MAX_ENTRIES);
         1:       n = $urandom_range(MAX_ENTRIES + 1, 65535);
         default: n = $urandom_range(1, 6);
      endcase
      live = (n > MAX_ENTRIES) ? MAX_ENTRIES : n;
      send(CMD_RESIZE, ENTRY_W'($urandom()), AMOUNT_W'(n), RANDOM_W'($urandom()));
      if (live > 6 || $urandom_range(0, 3) == 0) begin
         send(CMD_EQUAL, ENTRY_W'($urandom()),
              ($urandom_range(0, 19) == 0) ? AMOUNT_W'($urandom())
                                           : AMOUNT_W'($urandom_range(0, 3)),
              RANDOM_W'($urandom()));
      end else begin
         for (k = 0; k < live; k++)
            send(CMD_SET, ENTRY_W'(k), AMOUNT_W'($urandom_range(0, 4)), RANDOM_W'($urandom()));
      end
      if ($urandom_range(0, 2) == 0)
         send(CMD_INC, ENTRY_W'($urandom_range(0, live - 1)), AMOUNT_W'($urandom()),
              RANDOM_W'($urandom()));
      draws = $urandom_range(1, (live * 4 + 4 > 40) ? 40 : live * 4 + 4);
      repeat (draws) begin
         case ($urandom_range(0, 24))
            0:       send(CMD_RESTART, ENTRY_W'($urandom()), AMOUNT_W'($urandom()),
                          RANDOM_W'($urandom()));
            1:       send(CMD_SET, ENTRY_W'($urandom_range(0, live - 1)),
                          AMOUNT_W'($urandom_range(0, 3)), RANDOM_W'($urandom()));
            default: draw(RANDOM_W'($urandom()));
         endcase
      end
   endtask

   initial begin
      req_chan.valid       <= 1'b0;
      req_chan.command     <= '0;
      req_chan.entry_index <= '0;
      req_chan.amount      <= '0;
      req_chan.random_word <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // single entry of weight one: the first two draws each end the cycle
      draw('0);
      draw({RANDOM_W{1'b1}});
      send(CMD_SET, 6'd1, 16'd5, '0);
      send(CMD_INC, {ENTRY_W{1'b1}}, '0, '0);
      send(CMD_RESIZE, '0, 16'd0, '0);
      send(CMD_RESIZE, '0, {AMOUNT_W{1'b1}}, '0);
      send(CMD_SET, 6'd63, {AMOUNT_W{1'b1}}, '0);
      send(CMD_INC, 6'd63, '0, '0);
      send(CMD_SET, 6'd0, 16'd0, '0);
      draw({RANDOM_W{1'b1}});
      draw('0);
      send(CMD_EQUAL, '0, 16'd0, '0);
      send(CMD_EQUAL, '0, {AMOUNT_W{1'b1}}, '0);
      send(CMD_RESTART, '0, '0, '0);
      // small urn driven to empty, then an entry whose count reaches its lowered weight
      send(CMD_RESIZE, '0, 16'd3, '0);
      send(CMD_SET, 6'd0, 16'd0, '0);
      send(CMD_SET, 6'd1, 16'd0, '0);
      send(CMD_SET, 6'd2, 16'd0, '0);
      draw(31'd12345);
      send(CMD_SET, 6'd2, 16'd2, '0);
      draw(31'd7);
      send(CMD_SET, 6'd2, 16'd1, '0);
      send(CMD_SET, 6'd1, 16'd1, '0);
      draw(31'd1);
      send(CMD_SPARE_LO, {ENTRY_W{1'b1}}, {AMOUNT_W{1'b1}}, {RANDOM_W{1'b1}});
      send(CMD_SPARE_HI, '0, '0, '0);

      while (sent < RANDOM_ITEMS + 25) begin
         if ($urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(1, 4))
               send(CMD_W'($urandom_range(0, 7)), ENTRY_W'($urandom()), AMOUNT_W'($urandom()),
                    RANDOM_W'($urandom()));
         end else begin
            fill_and_drain();
         end
      end
      req_chan.valid <= 1'b0;

      while (awaited_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // result side: random stalls, calm stretches, and one long hold that backs up the input
   initial begin
      int gap;
      rsp_chan.ready <= 1'b0;
      forever begin
         if (received == 150)
            gap = HOLD_CYCLES;
         else
            gap = calm_receiver ? 0 : $urandom_range(0, 12);
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         received++;
         if (received % 40 == 0) calm_receiver = ($urandom_range(0, 3) == 0);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
